FILE: rtl/mct_pkg.sv
// ============================================================================
// mct_pkg
// Shared constants and types for the multiset counter table.
// ============================================================================
`default_nettype none

package mct_pkg;

    // Default sizes of the table.
    localparam int MCT_ENTRIES    = 64;
    localparam int MCT_KEY_BITS   = 32;
    localparam int MCT_COUNT_BITS = 16;

    // Item kinds.
    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic cmp_en;   // capture the match result for the incoming key
        logic add_go;   // commit an add item this cycle
        logic hit;      // some cell matched the key of the committed item
    } mct_cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/mct_cell.sv
// ============================================================================
// mct_cell
// One table entry: key, occurrence count, valid bit and match flag.
// ============================================================================
`default_nettype none

module mct_cell
    import mct_pkg::*;
#(
    parameter int KEY_BITS   = MCT_KEY_BITS,
    parameter int COUNT_BITS = MCT_COUNT_BITS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire mct_cell_ctrl_t        ctrl,
    input  wire logic [KEY_BITS-1:0]   key_in,
    input  wire logic                  prev_valid,
    output logic                       valid,
    output logic                       match,
    output logic [COUNT_BITS-1:0]      sel_count
);

    logic                  valid_reg;
    logic                  valid_next;
    logic                  match_reg;
    logic                  match_next;
    logic [KEY_BITS-1:0]   key_reg;
    logic [KEY_BITS-1:0]   key_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic                  load;
    logic                  inc;

    // The first free cell after a run of valid cells takes a new key.
    assign load = ctrl.add_go && !ctrl.hit && !valid_reg && prev_valid;
    assign inc  = ctrl.add_go && match_reg && (count_reg != {COUNT_BITS{1'b1}});

    always_comb begin
        valid_next = valid_reg | load;
        key_next   = load ? key_in : key_reg;
        count_next = count_reg;
        if (load) begin
            count_next = COUNT_BITS'(1);
        end else if (inc) begin
            count_next = count_reg + COUNT_BITS'(1);
        end
        match_next = ctrl.cmp_en ? (valid_reg && (key_reg == key_in)) : match_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg   <= key_next;
        count_reg <= count_next;
    end

    assign valid     = valid_reg;
    assign match     = match_reg;
    assign sel_count = match_reg ? count_reg : '0;

endmodule

`default_nettype wire

FILE: rtl/mct_popular.sv
// ============================================================================
// mct_popular
// Tracks the earliest-inserted key holding the greatest count.
// ============================================================================
`default_nettype none

module mct_popular
    import mct_pkg::*;
#(
    parameter int ENTRIES    = MCT_ENTRIES,
    parameter int KEY_BITS   = MCT_KEY_BITS,
    parameter int COUNT_BITS = MCT_COUNT_BITS,
    localparam int IDX_W     = $clog2(ENTRIES)
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  go,
    input  wire logic [KEY_BITS-1:0]   cand_key,
    input  wire logic [IDX_W-1:0]      cand_idx,
    input  wire logic [COUNT_BITS-1:0] cand_cnt,
    output logic [KEY_BITS-1:0]        pop_key_next
);

    logic [KEY_BITS-1:0]   pop_key_reg;
    logic [COUNT_BITS-1:0] pop_cnt_reg;
    logic [COUNT_BITS-1:0] pop_cnt_next;
    logic [IDX_W-1:0]      pop_idx_reg;
    logic [IDX_W-1:0]      pop_idx_next;
    logic                  take;

    // Counts only grow, so the only entry that can overtake the leader is the
    // one that just changed. On equal counts the earlier entry wins.
    assign take = go && ((cand_cnt > pop_cnt_reg) ||
                         ((cand_cnt == pop_cnt_reg) && (cand_idx < pop_idx_reg)));

    assign pop_key_next = take ? cand_key : pop_key_reg;
    assign pop_cnt_next = take ? cand_cnt : pop_cnt_reg;
    assign pop_idx_next = take ? cand_idx : pop_idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pop_cnt_reg <= '0;
            pop_idx_reg <= '0;
        end else begin
            pop_cnt_reg <= pop_cnt_next;
            pop_idx_reg <= pop_idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        pop_key_reg <= pop_key_next;
    end

endmodule

`default_nettype wire

FILE: rtl/multiset_counter_table_core.sv
// ============================================================================
// multiset_counter_table_core
// Bag of keys with occurrence counts, kept in insertion order in a row of cells.
// ============================================================================
// Sequencing: an accepted item is looked up in IDLE, then committed in UPDATE
//   once the output register is free; the match flags registered in the cells
//   split the lookup cycle from the update cycle, and one item is in flight.
// Reset: synchronous, active low; the table empties, the used count and the
//   leader tracker clear, and no result is pending.
// ============================================================================
`default_nettype none

module multiset_counter_table_core
    import mct_pkg::*;
#(
    parameter int ENTRIES    = MCT_ENTRIES,
    parameter int KEY_BITS   = MCT_KEY_BITS,
    parameter int COUNT_BITS = MCT_COUNT_BITS,
    localparam int IDX_W     = $clog2(ENTRIES),
    localparam int CNT_W     = $clog2(ENTRIES + 1)
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_kind,
    input  wire logic [KEY_BITS-1:0]   s_key,

    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [COUNT_BITS-1:0]      m_occurrences,
    output logic [CNT_W-1:0]           m_distinct_entries,
    output logic [KEY_BITS-1:0]        m_popular_key,
    output logic                       m_bag_empty,
    output logic                       m_add_dropped
);

    // Sequencer states. In IDLE the block takes an item and every cell
    // compares its key at once; in UPDATE the registered match flags drive
    // the count update, the append and the result.
    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_UPDATE = 1'b1;

    logic                  state_reg;
    logic                  state_next;

    logic                  kind_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [CNT_W-1:0]      used_reg;
    logic [CNT_W-1:0]      used_next;

    logic                  m_valid_reg;
    logic                  m_valid_next;
    logic [COUNT_BITS-1:0] m_occurrences_reg;
    logic [CNT_W-1:0]      m_distinct_entries_reg;
    logic [KEY_BITS-1:0]   m_popular_key_reg;
    logic                  m_bag_empty_reg;
    logic                  m_add_dropped_reg;

    logic                  in_accept;
    logic                  commit;
    logic                  is_add;
    logic                  full;
    logic                  hit;
    logic                  sat;
    logic                  append;
    logic                  pop_go;
    logic [IDX_W-1:0]      hit_idx;
    logic [COUNT_BITS-1:0] hit_cnt;
    logic [COUNT_BITS-1:0] new_cnt;
    logic [COUNT_BITS-1:0] occ;
    logic [IDX_W-1:0]      cand_idx;
    logic [COUNT_BITS-1:0] cand_cnt;
    logic [KEY_BITS-1:0]   pop_key_next;
    logic [KEY_BITS-1:0]   cell_key_in;

    mct_cell_ctrl_t        ctrl;

    logic [ENTRIES-1:0]    cell_valid;
    logic [ENTRIES-1:0]    cell_match;
    logic [COUNT_BITS-1:0] cell_count [ENTRIES];

    // ------------------------------------------------------------------------
    // Handshake and sequencing. The output register parts the two sides: a new
    // item is taken while a finished result still waits, and the update step
    // only stalls when the output register is still occupied.
    // ------------------------------------------------------------------------
    assign s_ready   = (state_reg == ST_IDLE);
    assign in_accept = s_valid && s_ready;
    assign commit    = (state_reg == ST_UPDATE) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (commit) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Reduction of the match flags. Keys in the table are distinct, so at most
    // one cell matches and a plain OR yields its index and count.
    // ------------------------------------------------------------------------
    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        hit_cnt = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            hit     = hit | cell_match[i];
            hit_idx = hit_idx | (cell_match[i] ? IDX_W'(i) : '0);
            hit_cnt = hit_cnt | cell_count[i];
        end
    end

    assign is_add  = (kind_reg == KIND_ADD);
    assign full    = (used_reg == CNT_W'(ENTRIES));
    assign sat     = (hit_cnt == {COUNT_BITS{1'b1}});
    assign new_cnt = sat ? hit_cnt : hit_cnt + COUNT_BITS'(1);
    assign append  = commit && is_add && !hit && !full;

    // An add of a present key reports its new count; an add of a new key
    // reports 1 unless the table is full; a query reports the stored count,
    // which is already zero when nothing matched.
    always_comb begin
        if (!is_add) begin
            occ = hit_cnt;
        end else if (hit) begin
            occ = new_cnt;
        end else if (!full) begin
            occ = COUNT_BITS'(1);
        end else begin
            occ = '0;
        end
    end

    assign used_next = append ? used_reg + CNT_W'(1) : used_reg;

    // The leader can only change when a count really changes.
    assign pop_go   = commit && is_add && ((hit && !sat) || (!hit && !full));
    assign cand_idx = hit ? hit_idx : used_reg[IDX_W-1:0];
    assign cand_cnt = hit ? new_cnt : COUNT_BITS'(1);

    // ------------------------------------------------------------------------
    // Row of cells. During the lookup cycle every cell sees the incoming key;
    // during the update cycle it sees the held key for an append. Each cell
    // hands its valid bit to its right neighbor, which marks the first free
    // cell as the append slot.
    // ------------------------------------------------------------------------
    assign cell_key_in = (state_reg == ST_IDLE) ? s_key : key_reg;

    assign ctrl.cmp_en = in_accept;
    assign ctrl.add_go = commit && is_add;
    assign ctrl.hit    = hit;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        logic prev_valid;

        if (g == 0) begin : g_first
            assign prev_valid = 1'b1;
        end else begin : g_rest
            assign prev_valid = cell_valid[g-1];
        end

        mct_cell #(
            .KEY_BITS   (KEY_BITS),
            .COUNT_BITS (COUNT_BITS)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .key_in     (cell_key_in),
            .prev_valid (prev_valid),
            .valid      (cell_valid[g]),
            .match      (cell_match[g]),
            .sel_count  (cell_count[g])
        );
    end

    mct_popular #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_popular (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .go           (pop_go),
        .cand_key     (key_reg),
        .cand_idx     (cand_idx),
        .cand_cnt     (cand_cnt),
        .pop_key_next (pop_key_next)
    );

    // ------------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------------
    always_comb begin
        m_valid_next = m_valid_reg;
        if (commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            used_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            kind_reg <= s_kind;
            key_reg  <= s_key;
        end
        if (commit) begin
            m_occurrences_reg      <= occ;
            m_distinct_entries_reg <= used_next;
            m_bag_empty_reg        <= (used_next == '0);
            m_popular_key_reg      <= (used_next == '0) ? '0 : pop_key_next;
            m_add_dropped_reg      <= is_add && !hit && full;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_occurrences      = m_occurrences_reg;
    assign m_distinct_entries = m_distinct_entries_reg;
    assign m_popular_key      = m_popular_key_reg;
    assign m_bag_empty        = m_bag_empty_reg;
    assign m_add_dropped      = m_add_dropped_reg;

endmodule

`default_nettype wire
